>>> design/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Types, codes and defaults shared by the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int WORD_BITS_DEF = 32;

    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_MUL = 4'd1;
    localparam logic [3:0] OP_DIV = 4'd2;
    localparam logic [3:0] OP_EQ  = 4'd3;
    localparam logic [3:0] OP_NE  = 4'd4;
    localparam logic [3:0] OP_LT  = 4'd5;
    localparam logic [3:0] OP_GT  = 4'd6;
    localparam logic [3:0] OP_LE  = 4'd7;
    localparam logic [3:0] OP_GE  = 4'd8;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef struct packed {
        logic [3:0]         op;
        logic signed [31:0] left_whole;
        logic signed [31:0] left_numerator;
        logic signed [31:0] left_denominator;
        logic signed [31:0] right_whole;
        logic signed [31:0] right_numerator;
        logic signed [31:0] right_denominator;
    } rau_in_t;

    typedef struct packed {
        logic signed [31:0] result_whole;
        logic signed [31:0] result_numerator;
        logic [30:0]        result_denominator;
        logic               compare_true;
        logic [1:0]         status;
    } rau_out_t;

    typedef enum logic [2:0] {
        FN_MUL,
        FN_DIV,
        FN_GCD,
        FN_ADD,
        FN_SUB
    } rau_fn_t;

    typedef struct packed {
        logic    start;
        rau_fn_t fn;
    } rau_cmd_t;

    typedef struct packed {
        logic done;
        logic swapped;
    } rau_rsp_t;

    typedef enum logic [1:0] {
        C_IDLE,
        C_RUN,
        C_SHIFT
    } rau_core_state_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_IMPL,
        S_IMPR,
        S_DISPATCH,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_ADDSUB,
        S_CHK,
        S_GCD,
        S_DIVN,
        S_DIVD,
        S_DIVQ,
        S_FIN,
        S_OUT
    } rau_state_t;

endpackage

>>> design/rau_core.sv
// ----------------------------------------------------------------------------
// rau_core
// Shared iterative unit: shift-add multiply, restoring divide, binary GCD,
// add and magnitude subtract, all on one wide adder.
// ----------------------------------------------------------------------------
module rau_core
    import rau_pkg::*;
#(
    parameter int WIDE = 4 * WORD_BITS_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  rau_cmd_t        cmd,
    input  logic [WIDE-1:0] opa,
    input  logic [WIDE-1:0] opb,
    output rau_rsp_t        rsp,
    output logic [WIDE-1:0] res_q,
    output logic [WIDE-1:0] res_r
);

    localparam int AW = WIDE + 2;
    localparam int CW = $clog2(WIDE + 1);

    rau_core_state_t state_reg, state_next;
    rau_fn_t         fn_reg, fn_next;
    logic [WIDE-1:0] u_reg, u_next;
    logic [WIDE-1:0] v_reg, v_next;
    logic [WIDE-1:0] w_reg, w_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]   k_reg, k_next;
    logic            swap_reg, swap_next;
    logic            done_reg, done_next;

    logic [AW-1:0] add_x;
    logic [AW-1:0] add_y;
    logic          add_sub;
    logic [AW-1:0] sum;
    logic          sum_neg;

    always_comb
    begin
        add_x   = {2'b00, u_reg};
        add_y   = {2'b00, v_reg};
        add_sub = 1'b1;
        case (fn_reg)
            FN_MUL:
            begin
                add_x   = {2'b00, w_reg};
                add_y   = {2'b00, u_reg};
                add_sub = 1'b0;
            end
            FN_DIV:
            begin
                add_x = {1'b0, w_reg, u_reg[WIDE-1]};
            end
            FN_ADD:
            begin
                add_sub = 1'b0;
            end
            default:
            begin
                add_sub = 1'b1;
            end
        endcase
    end

    assign sum     = add_x + (add_sub ? ~add_y : add_y) + AW'(add_sub);
    assign sum_neg = sum[AW-1];

    always_comb
    begin
        state_next = state_reg;
        fn_next    = fn_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        w_next     = w_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        swap_next  = swap_reg;
        done_next  = 1'b0;
        case (state_reg)
            C_IDLE:
            begin
                if (cmd.start)
                begin
                    fn_next    = cmd.fn;
                    u_next     = opa;
                    v_next     = opb;
                    w_next     = '0;
                    cnt_next   = CW'(WIDE);
                    k_next     = '0;
                    swap_next  = 1'b0;
                    state_next = C_RUN;
                end
            end
            C_RUN:
            begin
                case (fn_reg)
                    FN_MUL:
                    begin
                        if (v_reg == '0)
                        begin
                            u_next     = w_reg;
                            done_next  = 1'b1;
                            state_next = C_IDLE;
                        end
                        else
                        begin
                            if (v_reg[0])
                            begin
                                w_next = sum[WIDE-1:0];
                            end
                            u_next = {u_reg[WIDE-2:0], 1'b0};
                            v_next = {1'b0, v_reg[WIDE-1:1]};
                        end
                    end
                    FN_DIV:
                    begin
                        if (!sum_neg)
                        begin
                            w_next = sum[WIDE-1:0];
                        end
                        else
                        begin
                            w_next = {w_reg[WIDE-2:0], u_reg[WIDE-1]};
                        end
                        u_next   = {u_reg[WIDE-2:0], ~sum_neg};
                        cnt_next = cnt_reg - CW'(1);
                        if (cnt_reg == CW'(1))
                        begin
                            done_next  = 1'b1;
                            state_next = C_IDLE;
                        end
                    end
                    FN_GCD:
                    begin
                        if (u_reg == '0)
                        begin
                            state_next = C_SHIFT;
                        end
                        else if (!u_reg[0] && !v_reg[0])
                        begin
                            u_next = {1'b0, u_reg[WIDE-1:1]};
                            v_next = {1'b0, v_reg[WIDE-1:1]};
                            k_next = k_reg + CW'(1);
                        end
                        else if (!u_reg[0])
                        begin
                            u_next = {1'b0, u_reg[WIDE-1:1]};
                        end
                        else if (!v_reg[0])
                        begin
                            v_next = {1'b0, v_reg[WIDE-1:1]};
                        end
                        else if (sum_neg)
                        begin
                            u_next = v_reg;
                            v_next = u_reg;
                        end
                        else
                        begin
                            u_next = sum[WIDE-1:0];
                        end
                    end
                    FN_ADD:
                    begin
                        u_next     = sum[WIDE-1:0];
                        done_next  = 1'b1;
                        state_next = C_IDLE;
                    end
                    default:
                    begin
                        if (sum_neg)
                        begin
                            u_next    = v_reg;
                            v_next    = u_reg;
                            swap_next = 1'b1;
                        end
                        else
                        begin
                            u_next     = sum[WIDE-1:0];
                            done_next  = 1'b1;
                            state_next = C_IDLE;
                        end
                    end
                endcase
            end
            C_SHIFT:
            begin
                if (k_reg == '0)
                begin
                    u_next     = v_reg;
                    done_next  = 1'b1;
                    state_next = C_IDLE;
                end
                else
                begin
                    v_next = {v_reg[WIDE-2:0], 1'b0};
                    k_next = k_reg - CW'(1);
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fn_reg   <= fn_next;
        u_reg    <= u_next;
        v_reg    <= v_next;
        w_reg    <= w_next;
        cnt_reg  <= cnt_next;
        k_reg    <= k_next;
        swap_reg <= swap_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.swapped = swap_reg;
    assign res_q       = u_reg;
    assign res_r       = w_reg;

endmodule

>>> design/rational_arithmetic_unit_top.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top
// Compares run two multiplies and a magnitude subtract on the shared adder;
// add/multiply/divide also run a binary GCD and three restoring divides of
// 4*WORD_BITS steps (add first runs a third multiply and an add or subtract).
// Throughput: one transaction at a time; a finished result may wait in the
// output register while the next transaction is taken. Async reset, idle.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_top
    import rau_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     operand_valid,
    output logic     operand_stall,
    input  rau_in_t  operand,
    output logic     result_valid,
    input  logic     result_stall,
    output rau_out_t result
);

    localparam int W    = WORD_BITS;
    localparam int WIDE = 4 * W;
    localparam logic [WIDE-1:0] LIM = WIDE'(1) << (W - 1);

    rau_state_t state_reg, state_next;
    rau_in_t    in_reg, in_next;
    logic       issued_reg, issued_next;
    logic       lneg_reg, lneg_next, rneg_reg, rneg_next, neg_reg, neg_next;
    logic [2*W-1:0]  lm_reg, lm_next, rm_reg, rm_next;
    logic [W-1:0]    ld_reg, ld_next, rd_reg, rd_next;
    logic [WIDE-1:0] x_reg, x_next, y_reg, y_next, den_reg, den_next, g_reg, g_next;
    rau_out_t   res_reg, res_next, out_reg, out_next;
    logic       out_valid_reg, out_valid_next;

    rau_cmd_t        cmd;
    rau_rsp_t        rsp;
    logic [WIDE-1:0] opa, opb, res_q, res_r;

    logic [31:0]        sel_w, sel_n, sel_d;
    logic signed [W:0]  sw, sn, sd, adv, ew, en;
    logic               dneg;
    logic signed [2*W+1:0] nn, nn_abs;

    logic is_cmp, sa, sb, c_lt, c_eq, c_gt, ctrue, q_ovf, d_ovf;
    logic [31:0] q32, r32;

    rau_core #(.WIDE(WIDE)) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .opa   (opa),
        .opb   (opb),
        .rsp   (rsp),
        .res_q (res_q),
        .res_r (res_r)
    );

    // improper form of one operand
    always_comb
    begin
        if (state_reg == S_IMPR)
        begin
            sel_w = in_reg.right_whole;
            sel_n = in_reg.right_numerator;
            sel_d = in_reg.right_denominator;
        end
        else
        begin
            sel_w = in_reg.left_whole;
            sel_n = in_reg.left_numerator;
            sel_d = in_reg.left_denominator;
        end
        sw     = {sel_w[W-1], sel_w[W-1:0]};
        sn     = {sel_n[W-1], sel_n[W-1:0]};
        sd     = {sel_d[W-1], sel_d[W-1:0]};
        dneg   = sd[W];
        adv    = (sd == '0) ? (W+1)'(1) : (dneg ? -sd : sd);
        ew     = sw;
        en     = dneg ? -sn : sn;
        nn     = $signed({{(W+1){ew[W]}}, ew}) * $signed({{(W+1){adv[W]}}, adv})
                 + $signed({{(W+1){en[W]}}, en});
        nn_abs = nn[2*W+1] ? -nn : nn;
    end

    // comparison and result shaping
    always_comb
    begin
        is_cmp = (in_reg.op == OP_EQ) || (in_reg.op == OP_NE) || (in_reg.op == OP_LT)
                 || (in_reg.op == OP_GT) || (in_reg.op == OP_LE) || (in_reg.op == OP_GE);
        sa    = lneg_reg && (lm_reg != '0);
        sb    = rneg_reg && (rm_reg != '0);
        c_eq  = (sa == sb) && (res_q == '0);
        c_lt  = (sa && !sb) || ((sa == sb) && (sa ? (!rsp.swapped && res_q != '0)
                                                   : rsp.swapped));
        c_gt  = !c_lt && !c_eq;
        case (in_reg.op)
            OP_EQ:   ctrue = c_eq;
            OP_NE:   ctrue = !c_eq;
            OP_LT:   ctrue = c_lt;
            OP_GT:   ctrue = c_gt;
            OP_LE:   ctrue = !c_gt;
            OP_GE:   ctrue = !c_lt;
            default: ctrue = 1'b0;
        endcase
        d_ovf = y_reg >= LIM;
        q_ovf = (x_reg > LIM) || ((x_reg == LIM) && !neg_reg);
        q32   = x_reg[31:0];
        r32   = g_reg[31:0];
    end

    // core command
    always_comb
    begin
        cmd.start = 1'b0;
        cmd.fn    = FN_MUL;
        opa       = WIDE'(lm_reg);
        opb       = WIDE'(rd_reg);
        case (state_reg)
            S_MUL1:
            begin
                cmd.start = !issued_reg;
                opb       = (in_reg.op == OP_MUL) ? WIDE'(rm_reg) : WIDE'(rd_reg);
            end
            S_MUL2:
            begin
                cmd.start = !issued_reg;
                opa       = WIDE'(ld_reg);
                opb       = (in_reg.op == OP_MUL) ? WIDE'(rd_reg) : WIDE'(rm_reg);
            end
            S_MUL3:
            begin
                cmd.start = !issued_reg;
                opa       = WIDE'(ld_reg);
                opb       = WIDE'(rd_reg);
            end
            S_ADDSUB:
            begin
                cmd.start = !issued_reg;
                cmd.fn    = ((in_reg.op == OP_ADD) && (lneg_reg == rneg_reg)) ? FN_ADD : FN_SUB;
                opa       = x_reg;
                opb       = y_reg;
            end
            S_GCD:
            begin
                cmd.start = !issued_reg;
                cmd.fn    = FN_GCD;
                opa       = x_reg;
                opb       = y_reg;
            end
            S_DIVN:
            begin
                cmd.start = !issued_reg;
                cmd.fn    = FN_DIV;
                opa       = x_reg;
                opb       = g_reg;
            end
            S_DIVD:
            begin
                cmd.start = !issued_reg;
                cmd.fn    = FN_DIV;
                opa       = y_reg;
                opb       = g_reg;
            end
            S_DIVQ:
            begin
                cmd.start = !issued_reg;
                cmd.fn    = FN_DIV;
                opa       = x_reg;
                opb       = y_reg;
            end
            default:
            begin
                cmd.start = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        in_next        = in_reg;
        issued_next    = issued_reg;
        lneg_next      = lneg_reg;
        rneg_next      = rneg_reg;
        neg_next       = neg_reg;
        lm_next        = lm_reg;
        rm_next        = rm_reg;
        ld_next        = ld_reg;
        rd_next        = rd_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        den_next       = den_reg;
        g_next         = g_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.start)
        begin
            issued_next = 1'b1;
        end
        if (rsp.done)
        begin
            issued_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (operand_valid)
                begin
                    in_next    = operand;
                    state_next = S_IMPL;
                end
            end
            S_IMPL:
            begin
                lneg_next  = nn[2*W+1];
                lm_next    = nn_abs[2*W-1:0];
                ld_next    = adv[W-1:0];
                state_next = S_IMPR;
            end
            S_IMPR:
            begin
                rneg_next  = nn[2*W+1];
                rm_next    = nn_abs[2*W-1:0];
                rd_next    = adv[W-1:0];
                state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                res_next.result_whole       = '0;
                res_next.result_numerator   = '0;
                res_next.result_denominator = 31'd1;
                res_next.compare_true       = 1'b0;
                res_next.status             = ST_OK;
                if (in_reg.op > OP_GE)
                begin
                    state_next = S_OUT;
                end
                else if ((in_reg.op == OP_DIV) && (rm_reg == '0))
                begin
                    res_next.status = ST_DIV0;
                    state_next      = S_OUT;
                end
                else
                begin
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                if (rsp.done)
                begin
                    x_next     = res_q;
                    state_next = S_MUL2;
                end
            end
            S_MUL2:
            begin
                if (rsp.done)
                begin
                    y_next   = res_q;
                    neg_next = lneg_reg ^ rneg_reg;
                    if (in_reg.op == OP_ADD)
                    begin
                        state_next = S_MUL3;
                    end
                    else if (is_cmp)
                    begin
                        state_next = S_ADDSUB;
                    end
                    else
                    begin
                        state_next = S_CHK;
                    end
                end
            end
            S_MUL3:
            begin
                if (rsp.done)
                begin
                    den_next   = res_q;
                    state_next = S_ADDSUB;
                end
            end
            S_ADDSUB:
            begin
                if (rsp.done)
                begin
                    if (is_cmp)
                    begin
                        res_next.compare_true = ctrue;
                        state_next            = S_OUT;
                    end
                    else
                    begin
                        x_next     = res_q;
                        y_next     = den_reg;
                        neg_next   = (lneg_reg == rneg_reg) ? lneg_reg :
                                     (rsp.swapped ? rneg_reg : lneg_reg);
                        state_next = S_CHK;
                    end
                end
            end
            S_CHK:
            begin
                state_next = (x_reg == '0) ? S_OUT : S_GCD;
            end
            S_GCD:
            begin
                if (rsp.done)
                begin
                    g_next     = res_q;
                    state_next = S_DIVN;
                end
            end
            S_DIVN:
            begin
                if (rsp.done)
                begin
                    x_next     = res_q;
                    state_next = S_DIVD;
                end
            end
            S_DIVD:
            begin
                if (rsp.done)
                begin
                    y_next     = res_q;
                    state_next = S_DIVQ;
                end
            end
            S_DIVQ:
            begin
                if (rsp.done)
                begin
                    x_next     = res_q;
                    g_next     = res_r;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (d_ovf || q_ovf)
                begin
                    res_next.status = ST_OVF;
                end
                else
                begin
                    res_next.result_whole       = neg_reg ? -q32 : q32;
                    res_next.result_numerator   = neg_reg ? -r32 : r32;
                    res_next.result_denominator = y_reg[30:0];
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg   <= in_next;
        lneg_reg <= lneg_next;
        rneg_reg <= rneg_next;
        neg_reg  <= neg_next;
        lm_reg   <= lm_next;
        rm_reg   <= rm_next;
        ld_reg   <= ld_next;
        rd_reg   <= rd_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        den_reg  <= den_next;
        g_reg    <= g_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    assign operand_stall = (state_reg != S_IDLE);
    assign result_valid  = out_valid_reg;
    assign result        = out_reg;

endmodule
